/* src/hsms_session_control_engine_assert.svh */
// Assertion macros for the HSMS session control engine; empty under SYNTH.
`ifndef HSMS_SESSION_CONTROL_ENGINE_ASSERT_SVH
`define HSMS_SESSION_CONTROL_ENGINE_ASSERT_SVH

`ifndef SYNTH
// Checked property, clocked on clk and held off while rst_n is low.
`define HSCE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("hsce assertion failed");
// Checked property that also holds during reset.
`define HSCE_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("hsce assertion failed");
`else
`define HSCE_ASSERT(label, clk, rst_n, prop)
`define HSCE_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

/* src/hsce_pkg.sv */
// Shared types, codes and helper functions for the HSMS session control engine.
`default_nettype none

package hsce_pkg;

    // Number of pending transaction slots and derived widths.
    localparam int PENDING_SLOTS = 8;
    localparam int SLOT_W        = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;

    // Control session id carried by every control message.
    localparam logic [15:0] CTRL_SID = 16'hFFFF;

    // Received SType codes.
    localparam logic [7:0] ST_DATA         = 8'd0;
    localparam logic [7:0] ST_SELECT_REQ   = 8'd1;
    localparam logic [7:0] ST_SELECT_RSP   = 8'd2;
    localparam logic [7:0] ST_DESELECT_REQ = 8'd3;
    localparam logic [7:0] ST_DESELECT_RSP = 8'd4;
    localparam logic [7:0] ST_LINKTEST_REQ = 8'd5;
    localparam logic [7:0] ST_LINKTEST_RSP = 8'd6;
    localparam logic [7:0] ST_REJECT_REQ   = 8'd7;
    localparam logic [7:0] ST_SEPARATE_REQ = 8'd9;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ACCEPT_SELECT     = 2'd0;
    localparam logic [1:0] CFG_PEND_LIMIT        = 2'd1;
    localparam logic [1:0] CFG_MAX_LINK_FAILURES = 2'd2;

    // Session mode.
    typedef enum logic [1:0] {
        MODE_DISC = 2'd0,
        MODE_CONN = 2'd1,
        MODE_SEL  = 2'd2
    } t_mode;

    // Request kinds.
    typedef enum logic [2:0] {
        REQ_HEADER   = 3'd0,
        REQ_REGISTER = 3'd1,
        REQ_RETIRE   = 3'd2,
        REQ_LINK     = 3'd3,
        REQ_LINKTEST = 3'd4
    } t_req;

    // Message to send.
    typedef enum logic [2:0] {
        SEND_NONE         = 3'd0,
        SEND_SELECT_RSP   = 3'd1,
        SEND_DESELECT_RSP = 3'd2,
        SEND_LINKTEST_RSP = 3'd3,
        SEND_REJECT_REQ   = 3'd4
    } t_send;

    // Error codes.
    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_TABLE_FULL = 2'd1,
        ERR_PROTOCOL   = 2'd2
    } t_err;

    // Input transaction.
    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] sess_id;
        logic [7:0]  s_type;
        logic [7:0]  status_byte;
        logic [31:0] sys_bytes;
        logic        event_flag;
    } t_hsms_req;

    // Result transaction.
    typedef struct packed {
        logic [2:0]  send_kind;
        logic        send_status;
        logic [15:0] echo_sess_id;
        logic [31:0] echo_sys_bytes;
        logic [7:0]  echo_type;
        logic        close_link;
        logic        deliver_data;
        logic        matched;
        logic [2:0]  matched_slot;
        logic [1:0]  err_code;
        logic [1:0]  mode_after;
        logic [7:0]  cancelled_slots;
    } t_hsms_rsp;

    // Update command for the pending table.
    typedef struct packed {
        logic [PENDING_SLOTS-1:0] clr;
        logic                     wr;
        logic [SLOT_W-1:0]        wr_slot;
        logic [31:0]              wr_sb;
        logic [7:0]               wr_ty;
    } t_tbl_upd;

    // Per-slot compare results of the pending table.
    typedef struct packed {
        logic [PENDING_SLOTS-1:0] valid;
        logic [PENDING_SLOTS-1:0] match;
        logic [PENDING_SLOTS-1:0] sb_eq;
        logic [PENDING_SLOTS-1:0] data;
    } t_tbl_stat;

    // Index of the lowest set bit; zero when no bit is set.
    function automatic logic [SLOT_W-1:0] lowest_set(input logic [PENDING_SLOTS-1:0] v);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = PENDING_SLOTS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = SLOT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

/* src/hsce_slot_table.sv */
// Pending transaction table with parallel compare against the current header.
`default_nettype none

module hsce_slot_table (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [31:0]          i_sb,
    input  wire logic [7:0]           i_ty,
    input  wire hsce_pkg::t_tbl_upd   i_upd,
    output hsce_pkg::t_tbl_stat       o_stat
);

    logic [hsce_pkg::PENDING_SLOTS-1:0] r_valid;
    logic [31:0]                        r_sb [hsce_pkg::PENDING_SLOTS];
    logic [7:0]                         r_ty [hsce_pkg::PENDING_SLOTS];
    logic [hsce_pkg::PENDING_SLOTS-1:0] n_valid;

    // Compare every slot against the header in parallel.
    always_comb begin
        for (int i = 0; i < hsce_pkg::PENDING_SLOTS; i++) begin
            o_stat.valid[i] = r_valid[i];
            o_stat.sb_eq[i] = r_valid[i] && (r_sb[i] == i_sb);
            o_stat.match[i] = r_valid[i] && (r_sb[i] == i_sb) && (r_ty[i] == i_ty);
            o_stat.data[i]  = r_valid[i] && (r_ty[i] == hsce_pkg::ST_DATA);
        end
    end

    // Clears apply first; a write then marks its slot valid.
    always_comb begin
        n_valid = r_valid & ~i_upd.clr;
        if (i_upd.wr) begin
            n_valid[i_upd.wr_slot] = 1'b1;
        end
    end

    // Valid bits are control state and reset; entry contents are written before use.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.wr) begin
            r_sb[i_upd.wr_slot] <= i_upd.wr_sb;
            r_ty[i_upd.wr_slot] <= i_upd.wr_ty;
        end
    end

endmodule

`default_nettype wire

/* src/hsms_session_control_engine.sv */
// HSMS-SS session control engine: session mode, pending table and linktest failures.
//
// Usage:
// - Input channel (i_in_valid, o_in_stall, i_in_data) carries one request per
//   transaction: a received header, a register or retire of a pending
//   transaction, a link event or a linktest outcome.
// - Output channel (o_out_valid, i_out_stall, o_out_data) returns exactly one
//   result per request, in order.
// - Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_wdata);
//   the user must write it only while no request is in flight; the block does not enforce this.
// Timing:
// - A request accepted into the input register is decided there, and its result
//   is registered in the output register when the request fires; a stalled output
//   holds the request in the input register until then.
// - One request per cycle is sustained while the receiver does not stall; the decision
//   for a request is combinational logic around the table's eight-slot parallel compare.
// - When the receiver stalls, the held result stays put and one more request
//   waits in the input register; after that o_in_stall rises.
// Reset (synchronous, active low) sets the link disconnected, clears the
// table and the failure count, and restores the configuration defaults.
`default_nettype none

`include "hsms_session_control_engine_assert.svh"

module hsms_session_control_engine (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire hsce_pkg::t_hsms_req i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output hsce_pkg::t_hsms_rsp      o_out_data,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_idx,
    input  wire logic [7:0]          i_cfg_wdata
);

    // Configuration registers.
    logic       r_accept_select;
    logic [3:0] r_pend_limit;
    logic [7:0] r_max_link_fail;

    // Pipeline registers.
    logic                r_in_vld;
    hsce_pkg::t_hsms_req r_in;
    logic                r_out_vld;
    hsce_pkg::t_hsms_rsp r_out;

    // Session state.
    hsce_pkg::t_mode r_mode;
    hsce_pkg::t_mode n_mode;
    logic [7:0]      r_fail_cnt;
    logic [7:0]      n_fail_cnt;

    // Decision signals.
    logic                               adv;
    logic                               fire;
    hsce_pkg::t_tbl_upd                 upd;
    hsce_pkg::t_tbl_stat                stat;
    hsce_pkg::t_hsms_rsp                n_rsp;
    hsce_pkg::t_send                    send;
    hsce_pkg::t_err                     err;
    logic [hsce_pkg::PENDING_SLOTS-1:0] cancel;
    logic [hsce_pkg::PENDING_SLOTS-1:0] retire_clr;
    logic [hsce_pkg::SLOT_W-1:0]        mslot;
    logic                               sstat;
    logic                               close;
    logic                               deliver;
    logic                               match;
    logic [7:0]                         etype;
    logic [7:0]                         pend_cnt;
    logic [7:0]                         pend_lim;
    logic [7:0]                         fail_lim;
    logic [7:0]                         fail_inc;

    // The input register advances when the output register is free or being taken.
    assign adv        = !r_out_vld || !i_out_stall;
    assign fire       = r_in_vld && adv;
    assign o_in_stall = r_in_vld && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    // Configuration writes; indexes beyond the register list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_select <= 1'b1;
            r_pend_limit    <= 4'd8;
            r_max_link_fail <= 8'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hsce_pkg::CFG_ACCEPT_SELECT:     r_accept_select <= i_cfg_wdata[0];
                hsce_pkg::CFG_PEND_LIMIT:        r_pend_limit    <= i_cfg_wdata[3:0];
                hsce_pkg::CFG_MAX_LINK_FAILURES: r_max_link_fail <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pending table.
    hsce_slot_table u_slot_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sb    (r_in.sys_bytes),
        .i_ty    (r_in.s_type),
        .i_upd   (upd),
        .o_stat  (stat)
    );

    // Limits: a zero limit counts as one, the pending limit is capped at the table size.
    always_comb begin
        pend_cnt = 8'($countones(stat.valid));
        if (r_pend_limit == 4'd0) begin
            pend_lim = 8'd1;
        end else if (8'(r_pend_limit) > 8'(hsce_pkg::PENDING_SLOTS)) begin
            pend_lim = 8'(hsce_pkg::PENDING_SLOTS);
        end else begin
            pend_lim = 8'(r_pend_limit);
        end
        fail_lim = (r_max_link_fail == 8'd0) ? 8'd1 : r_max_link_fail;
        fail_inc = (r_fail_cnt == 8'hFF) ? r_fail_cnt : r_fail_cnt + 8'd1;
    end

    // Session decision and next state for the request in the input register.
    always_comb begin
        n_mode      = r_mode;
        n_fail_cnt  = r_fail_cnt;
        send        = hsce_pkg::SEND_NONE;
        err         = hsce_pkg::ERR_NONE;
        sstat       = 1'b0;
        close       = 1'b0;
        deliver     = 1'b0;
        match       = 1'b0;
        mslot       = '0;
        etype       = 8'd0;
        cancel      = '0;
        retire_clr  = '0;
        upd.wr      = 1'b0;
        upd.wr_slot = '0;
        upd.wr_sb   = r_in.sys_bytes;
        upd.wr_ty   = r_in.s_type;

        case (hsce_pkg::t_req'(r_in.req_type))
            hsce_pkg::REQ_HEADER: begin
                if (r_mode != hsce_pkg::MODE_DISC) begin
                    if (r_in.s_type == hsce_pkg::ST_DATA) begin
                        // Data: fulfills a pending entry or goes inbound when selected.
                        if (|stat.match) begin
                            match = 1'b1;
                            mslot = hsce_pkg::lowest_set(stat.match);
                        end else if (r_mode == hsce_pkg::MODE_SEL) begin
                            deliver = 1'b1;
                        end
                    end else if (r_in.sess_id != hsce_pkg::CTRL_SID) begin
                        // Control message with a bad session id drops the link.
                        close      = 1'b1;
                        err        = hsce_pkg::ERR_PROTOCOL;
                        n_mode     = hsce_pkg::MODE_DISC;
                        n_fail_cnt = 8'd0;
                        cancel     = stat.valid;
                    end else begin
                        case (r_in.s_type)
                            hsce_pkg::ST_SELECT_REQ: begin
                                send = hsce_pkg::SEND_SELECT_RSP;
                                if (!r_accept_select) begin
                                    sstat  = 1'b1;
                                    n_mode = hsce_pkg::MODE_CONN;
                                    cancel = stat.data;
                                end else if (r_mode == hsce_pkg::MODE_SEL) begin
                                    sstat = 1'b1;
                                end else begin
                                    n_mode     = hsce_pkg::MODE_SEL;
                                    n_fail_cnt = 8'd0;
                                end
                            end
                            hsce_pkg::ST_SELECT_RSP: begin
                                if (|stat.match) begin
                                    match = 1'b1;
                                    mslot = hsce_pkg::lowest_set(stat.match);
                                    if (r_in.status_byte == 8'd0 &&
                                        r_mode != hsce_pkg::MODE_SEL) begin
                                        n_mode     = hsce_pkg::MODE_SEL;
                                        n_fail_cnt = 8'd0;
                                    end
                                end
                            end
                            hsce_pkg::ST_DESELECT_REQ: begin
                                send   = hsce_pkg::SEND_DESELECT_RSP;
                                n_mode = hsce_pkg::MODE_CONN;
                                cancel = stat.data;
                            end
                            hsce_pkg::ST_DESELECT_RSP: begin
                                if (|stat.match) begin
                                    match = 1'b1;
                                    mslot = hsce_pkg::lowest_set(stat.match);
                                end
                                n_mode = hsce_pkg::MODE_CONN;
                                cancel = stat.data;
                            end
                            hsce_pkg::ST_LINKTEST_RSP: begin
                                if (|stat.match) begin
                                    match = 1'b1;
                                    mslot = hsce_pkg::lowest_set(stat.match);
                                end
                            end
                            hsce_pkg::ST_LINKTEST_REQ: begin
                                send = hsce_pkg::SEND_LINKTEST_RSP;
                            end
                            hsce_pkg::ST_REJECT_REQ: begin
                                // A received reject needs no action here.
                            end
                            hsce_pkg::ST_SEPARATE_REQ: begin
                                close      = 1'b1;
                                n_mode     = hsce_pkg::MODE_DISC;
                                n_fail_cnt = 8'd0;
                                cancel     = stat.valid;
                            end
                            default: begin
                                // Unknown control type is answered with a reject.
                                send  = hsce_pkg::SEND_REJECT_REQ;
                                etype = r_in.s_type;
                            end
                        endcase
                    end
                end
            end
            hsce_pkg::REQ_REGISTER: begin
                // Reuse an entry with equal system bytes, else the lowest free slot.
                if (pend_cnt >= pend_lim) begin
                    err = hsce_pkg::ERR_TABLE_FULL;
                end else begin
                    upd.wr = 1'b1;
                    if (|stat.sb_eq) begin
                        upd.wr_slot = hsce_pkg::lowest_set(stat.sb_eq);
                    end else begin
                        upd.wr_slot = hsce_pkg::lowest_set(~stat.valid);
                    end
                    mslot = upd.wr_slot;
                end
            end
            hsce_pkg::REQ_RETIRE: begin
                if (|stat.sb_eq) begin
                    retire_clr[hsce_pkg::lowest_set(stat.sb_eq)] = 1'b1;
                end
            end
            hsce_pkg::REQ_LINK: begin
                n_fail_cnt = 8'd0;
                cancel     = stat.valid;
                if (!r_in.event_flag) begin
                    n_mode = hsce_pkg::MODE_CONN;
                end else begin
                    close  = 1'b1;
                    n_mode = hsce_pkg::MODE_DISC;
                end
            end
            hsce_pkg::REQ_LINKTEST: begin
                if (r_mode == hsce_pkg::MODE_SEL) begin
                    if (!r_in.event_flag) begin
                        n_fail_cnt = 8'd0;
                    end else if (fail_inc >= fail_lim) begin
                        close      = 1'b1;
                        n_mode     = hsce_pkg::MODE_DISC;
                        n_fail_cnt = 8'd0;
                        cancel     = stat.valid;
                    end else begin
                        n_fail_cnt = fail_inc;
                    end
                end
            end
            default: ;
        endcase

        upd.clr = cancel | retire_clr;

        // Only a firing request changes the table.
        if (!fire) begin
            upd.clr = '0;
            upd.wr  = 1'b0;
        end

        n_rsp.send_kind       = send;
        n_rsp.send_status     = sstat;
        n_rsp.echo_sess_id    = (send != hsce_pkg::SEND_NONE) ? r_in.sess_id : 16'd0;
        n_rsp.echo_sys_bytes  = (send != hsce_pkg::SEND_NONE) ? r_in.sys_bytes : 32'd0;
        n_rsp.echo_type       = etype;
        n_rsp.close_link      = close;
        n_rsp.deliver_data    = deliver;
        n_rsp.matched         = match;
        n_rsp.matched_slot    = 3'(mslot);
        n_rsp.err_code        = err;
        n_rsp.mode_after      = n_mode;
        n_rsp.cancelled_slots = 8'(cancel);
    end

    // Session state advances with each decided request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= hsce_pkg::MODE_DISC;
            r_fail_cnt <= 8'd0;
        end else if (fire) begin
            r_mode     <= n_mode;
            r_fail_cnt <= n_fail_cnt;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_rsp;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // A request held back by a stalled output keeps its place.
    `HSCE_ASSERT(a_in_hold, i_clk, i_rst_n, o_in_stall |=> r_in_vld && $stable(r_in))
    // Closing the link always leaves the session disconnected.
    `HSCE_ASSERT(a_close_disc, i_clk, i_rst_n,
        r_out_vld && r_out.close_link |-> r_out.mode_after == hsce_pkg::MODE_DISC)
    // Inbound data is only delivered while selected and never alongside a match.
    `HSCE_ASSERT(a_deliver_sel, i_clk, i_rst_n,
        r_out_vld && r_out.deliver_data |->
        r_out.mode_after == hsce_pkg::MODE_SEL && !r_out.matched)
    // Slots reported as cancelled are gone from the table right after.
    `HSCE_ASSERT(a_cancel_gone, i_clk, i_rst_n,
        fire |=> (8'(stat.valid) & r_out.cancelled_slots) == 8'd0)

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the HSMS-SS session control engine with an in-line session predictor.

// Tracks the session the way the engine should and checks each returned result.
class session_tracker;
    bit          accept_select     = 1'b1;
    logic [3:0]  pend_limit        = 4'd8;
    logic [7:0]  max_link_failures = 8'd3;

    hsce_pkg::t_mode mode = hsce_pkg::MODE_DISC;
    bit          slot_used [hsce_pkg::PENDING_SLOTS];
    logic [31:0] slot_sb   [hsce_pkg::PENDING_SLOTS];
    logic [7:0]  slot_ty   [hsce_pkg::PENDING_SLOTS];
    int unsigned link_failures;

    hsce_pkg::t_hsms_rsp awaited [$];
    int unsigned errors;
    int unsigned results_seen;

    function void set_config(bit acc, logic [7:0] mp, logic [7:0] mf);
        accept_select     = acc;
        pend_limit        = mp[3:0];
        max_link_failures = mf;
    endfunction

    function int pending();
        return awaited.size();
    endfunction

    // Frees every used slot, or only the ones waiting on data, and returns the mask.
    function logic [7:0] cancel_slots(bit data_only);
        logic [7:0] mask;
        mask = '0;
        for (int i = 0; i < hsce_pkg::PENDING_SLOTS; i++) begin
            if (slot_used[i] && (!data_only || slot_ty[i] == hsce_pkg::ST_DATA)) begin
                slot_used[i] = 1'b0;
                if (i < 8) mask[i] = 1'b1;
            end
        end
        return mask;
    endfunction

    // Lowest used slot that waits for this transaction id and type, or -1.
    function int find_slot(logic [31:0] sb, logic [7:0] ty);
        for (int i = 0; i < hsce_pkg::PENDING_SLOTS; i++) begin
            if (slot_used[i] && slot_sb[i] == sb && slot_ty[i] == ty) return i;
        end
        return -1;
    endfunction

    function logic [7:0] leave_selected();
        if (mode == hsce_pkg::MODE_DISC) return '0;
        mode = hsce_pkg::MODE_CONN;
        return cancel_slots(1'b1);
    endfunction

    function void enter_selected();
        if (mode != hsce_pkg::MODE_SEL) begin
            mode = hsce_pkg::MODE_SEL;
            link_failures = 0;
        end
    endfunction

    function logic [7:0] drop_link();
        mode = hsce_pkg::MODE_DISC;
        link_failures = 0;
        return cancel_slots(1'b0);
    endfunction

    // Works out the result of one accepted request and updates the session.
    function hsce_pkg::t_hsms_rsp predict(hsce_pkg::t_hsms_req r);
        hsce_pkg::t_hsms_rsp o;
        int        m;
        int        used;
        int        slot;
        int        lim;
        o = '0;
        if (r.req_type == hsce_pkg::REQ_HEADER && mode != hsce_pkg::MODE_DISC) begin
            if (r.s_type == hsce_pkg::ST_DATA) begin
                m = find_slot(r.sys_bytes, hsce_pkg::ST_DATA);
                if (m >= 0) begin
                    o.matched      = 1'b1;
                    o.matched_slot = 3'(m);
                end else if (mode == hsce_pkg::MODE_SEL) begin
                    o.deliver_data = 1'b1;
                end
            end else if (r.sess_id != hsce_pkg::CTRL_SID) begin
                o.close_link      = 1'b1;
                o.err_code        = hsce_pkg::ERR_PROTOCOL;
                o.cancelled_slots = drop_link();
            end else begin
                case (r.s_type)
                    hsce_pkg::ST_SELECT_REQ: begin
                        o.send_kind = hsce_pkg::SEND_SELECT_RSP;
                        if (!accept_select) begin
                            o.send_status     = 1'b1;
                            o.cancelled_slots = leave_selected();
                        end else if (mode == hsce_pkg::MODE_SEL) begin
                            o.send_status = 1'b1;
                        end else begin
                            enter_selected();
                        end
                    end
                    hsce_pkg::ST_SELECT_RSP: begin
                        m = find_slot(r.sys_bytes, r.s_type);
                        if (m >= 0) begin
                            o.matched      = 1'b1;
                            o.matched_slot = 3'(m);
                            if (r.status_byte == 8'd0) enter_selected();
                        end
                    end
                    hsce_pkg::ST_DESELECT_REQ: begin
                        o.cancelled_slots = leave_selected();
                        o.send_kind       = hsce_pkg::SEND_DESELECT_RSP;
                    end
                    hsce_pkg::ST_DESELECT_RSP, hsce_pkg::ST_LINKTEST_RSP: begin
                        m = find_slot(r.sys_bytes, r.s_type);
                        if (m >= 0) begin
                            o.matched      = 1'b1;
                            o.matched_slot = 3'(m);
                        end
                        if (r.s_type == hsce_pkg::ST_DESELECT_RSP)
                            o.cancelled_slots = leave_selected();
                    end
                    hsce_pkg::ST_LINKTEST_REQ: o.send_kind = hsce_pkg::SEND_LINKTEST_RSP;
                    hsce_pkg::ST_REJECT_REQ: ;
                    hsce_pkg::ST_SEPARATE_REQ: begin
                        o.close_link      = 1'b1;
                        o.cancelled_slots = drop_link();
                    end
                    default: begin
                        o.send_kind = hsce_pkg::SEND_REJECT_REQ;
                        o.echo_type = r.s_type;
                    end
                endcase
            end
        end else if (r.req_type == hsce_pkg::REQ_REGISTER) begin
            lim = (pend_limit == 0) ? 1 : int'(pend_limit);
            if (lim > hsce_pkg::PENDING_SLOTS) lim = hsce_pkg::PENDING_SLOTS;
            used = 0;
            slot = -1;
            for (int i = 0; i < hsce_pkg::PENDING_SLOTS; i++) if (slot_used[i]) used++;
            if (used >= lim) begin
                o.err_code = hsce_pkg::ERR_TABLE_FULL;
            end else begin
                // An entry with the same id is reused before any free slot.
                for (int i = 0; i < hsce_pkg::PENDING_SLOTS && slot < 0; i++)
                    if (slot_used[i] && slot_sb[i] == r.sys_bytes) slot = i;
                for (int i = 0; i < hsce_pkg::PENDING_SLOTS && slot < 0; i++)
                    if (!slot_used[i]) slot = i;
                slot_used[slot] = 1'b1;
                slot_sb[slot]   = r.sys_bytes;
                slot_ty[slot]   = r.s_type;
                o.matched_slot  = 3'(slot);
            end
        end else if (r.req_type == hsce_pkg::REQ_RETIRE) begin
            for (int i = 0; i < hsce_pkg::PENDING_SLOTS; i++) begin
                if (slot_used[i] && slot_sb[i] == r.sys_bytes) begin
                    slot_used[i] = 1'b0;
                    break;
                end
            end
        end else if (r.req_type == hsce_pkg::REQ_LINK) begin
            if (!r.event_flag) begin
                mode              = hsce_pkg::MODE_CONN;
                link_failures     = 0;
                o.cancelled_slots = cancel_slots(1'b0);
            end else begin
                o.close_link      = 1'b1;
                o.cancelled_slots = drop_link();
            end
        end else if (r.req_type == hsce_pkg::REQ_LINKTEST && mode == hsce_pkg::MODE_SEL) begin
            if (!r.event_flag) begin
                link_failures = 0;
            end else begin
                lim = (max_link_failures == 0) ? 1 : int'(max_link_failures);
                if (link_failures < 255) link_failures++;
                if (link_failures >= lim) begin
                    o.close_link      = 1'b1;
                    o.cancelled_slots = drop_link();
                end
            end
        end
        if (o.send_kind != hsce_pkg::SEND_NONE) begin
            o.echo_sess_id   = r.sess_id;
            o.echo_sys_bytes = r.sys_bytes;
        end
        o.mode_after = mode;
        return o;
    endfunction

    function void note_request(hsce_pkg::t_hsms_req r);
        awaited.insert(awaited.size(), predict(r));
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= 10)
                $display("result %0d, field %s: expected %0h, got %0h",
                         results_seen, name, want, got);
        end
    endfunction

    // Compares one returned result with the oldest prediction.
    function void check_response(hsce_pkg::t_hsms_rsp got);
        hsce_pkg::t_hsms_rsp want;
        results_seen++;
        if (awaited.size() == 0) begin
            errors++;
            if (errors <= 10) $display("result %0d arrived with none predicted: %h",
                                       results_seen, got);
            return;
        end
        want = awaited[0];
        awaited.delete(0);
        compare_field("send_kind", 32'(want.send_kind), 32'(got.send_kind));
        compare_field("send_status", 32'(want.send_status), 32'(got.send_status));
        compare_field("echo_sess_id", 32'(want.echo_sess_id), 32'(got.echo_sess_id));
        compare_field("echo_sys_bytes", want.echo_sys_bytes, got.echo_sys_bytes);
        compare_field("echo_type", 32'(want.echo_type), 32'(got.echo_type));
        compare_field("close_link", 32'(want.close_link), 32'(got.close_link));
        compare_field("deliver_data", 32'(want.deliver_data), 32'(got.deliver_data));
        compare_field("matched", 32'(want.matched), 32'(got.matched));
        compare_field("matched_slot", 32'(want.matched_slot), 32'(got.matched_slot));
        compare_field("err_code", 32'(want.err_code), 32'(got.err_code));
        compare_field("mode_after", 32'(want.mode_after), 32'(got.mode_after));
        compare_field("cancelled_slots", 32'(want.cancelled_slots),
                      32'(got.cancelled_slots));
    endfunction
endclass

module testbench;
    localparam int CYCLE_LIMIT = 1000000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    hsce_pkg::t_hsms_req in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    hsce_pkg::t_hsms_rsp out_data;
    logic      cfg_we    = 1'b0;
    logic [1:0] cfg_idx  = hsce_pkg::CFG_ACCEPT_SELECT;
    logic [7:0] cfg_wdata = 8'd0;

    session_tracker board = new;
    int          cycle_count = 0;
    bit          calm;
    logic [31:0] sb_pool [8];
    int          phase_cfg [8][3];

    hsms_session_control_engine uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Guard against a hung handshake.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("hsms_session_control_engine: mismatch");
            $finish;
        end
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic hsce_pkg::t_hsms_req build_request(hsce_pkg::t_req k,
                                                          logic [15:0] sid, logic [7:0] ty,
                                                          logic [7:0] st, logic [31:0] sb,
                                                          bit ev);
        hsce_pkg::t_hsms_req r;
        r.req_type    = k;
        r.sess_id     = sid;
        r.s_type      = ty;
        r.status_byte = st;
        r.sys_bytes   = sb;
        r.event_flag  = ev;
        return r;
    endfunction

    // Mostly well-formed session traffic, steered by the predicted mode, with some noise.
    function automatic hsce_pkg::t_hsms_req random_request();
        hsce_pkg::t_hsms_req r;
        int        roll;
        int        kind;
        roll          = $urandom_range(0, 99);
        r.req_type    = hsce_pkg::REQ_HEADER;
        r.sess_id     = hsce_pkg::CTRL_SID;
        r.s_type      = hsce_pkg::ST_DATA;
        r.status_byte = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom);
        r.sys_bytes   = ($urandom_range(0, 3) == 0) ? $urandom : sb_pool[$urandom_range(0, 7)];
        r.event_flag  = 1'($urandom);
        if ($urandom_range(0, 19) == 0) sb_pool[$urandom_range(0, 7)] = $urandom;
        if (board.mode == hsce_pkg::MODE_DISC && roll < 40) begin
            r.req_type   = hsce_pkg::REQ_LINK;
            r.event_flag = 1'b0;
        end else if (roll < 2) begin
            r.req_type = 3'($urandom_range(5, 7));
            r.sess_id  = 16'($urandom);
            r.s_type   = 8'($urandom);
        end else if (roll < 6) begin
            r.req_type   = hsce_pkg::REQ_LINK;
            r.event_flag = ($urandom_range(0, 4) == 0);
        end else if (roll < 14) begin
            r.req_type   = hsce_pkg::REQ_LINKTEST;
            r.event_flag = ($urandom_range(0, 4) < 2);
        end else if (roll < 32) begin
            r.req_type = hsce_pkg::REQ_REGISTER;
            kind       = $urandom_range(0, 9);
            r.s_type   = (kind < 8) ? 8'(2 * (kind % 4)) : 8'($urandom);
        end else if (roll < 40) begin
            r.req_type = hsce_pkg::REQ_RETIRE;
        end else if (board.mode == hsce_pkg::MODE_CONN && roll < 55) begin
            r.s_type = hsce_pkg::ST_SELECT_REQ;
        end else begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                r.s_type  = hsce_pkg::ST_DATA;
                r.sess_id = 16'($urandom);
            end
            else if (kind < 40) r.s_type = hsce_pkg::ST_SELECT_REQ;
            else if (kind < 50) r.s_type = hsce_pkg::ST_SELECT_RSP;
            else if (kind < 55) r.s_type = hsce_pkg::ST_DESELECT_REQ;
            else if (kind < 62) r.s_type = hsce_pkg::ST_DESELECT_RSP;
            else if (kind < 72) r.s_type = hsce_pkg::ST_LINKTEST_REQ;
            else if (kind < 84) r.s_type = hsce_pkg::ST_LINKTEST_RSP;
            else if (kind < 88) r.s_type = hsce_pkg::ST_REJECT_REQ;
            else if (kind < 90) r.s_type = hsce_pkg::ST_SEPARATE_REQ;
            else r.s_type = 8'($urandom);
            if (r.s_type != hsce_pkg::ST_DATA && $urandom_range(0, 19) == 0)
                r.sess_id = 16'($urandom);
        end
        return r;
    endfunction

    // Presents one request after a random gap and holds it until the engine takes it.
    task automatic send_req(input hsce_pkg::t_hsms_req r);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do @(posedge clk); while (in_stall);
        board.note_request(r);
    endtask

    // Stops sending and waits until every predicted result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input bit acc, input logic [7:0] mp, input logic [7:0] mf);
        cfg_we    <= 1'b1;
        cfg_idx   <= hsce_pkg::CFG_ACCEPT_SELECT;
        cfg_wdata <= {7'd0, acc};
        @(posedge clk);
        cfg_idx   <= hsce_pkg::CFG_PEND_LIMIT;
        cfg_wdata <= mp;
        @(posedge clk);
        cfg_idx   <= hsce_pkg::CFG_MAX_LINK_FAILURES;
        cfg_wdata <= mf;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.set_config(acc, mp, mf);
    endtask

    // Result side: stall for a random number of cycles, then take the next transaction.
    initial begin
        int n;
        wait (rst_n);
        forever begin
            n = draw_gap();
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            board.check_response(out_data);
        end
    end

    // Request side: reset, directed sequence, then randomized phases under several settings.
    initial begin
        sb_pool = '{32'h0, 32'hFFFFFFFF, 32'h1, 32'h80000000,
                    32'h12345678, 32'hA5A5A5A5, 32'h7, 32'h0000FFFF};
        phase_cfg = '{'{0, 0, 0}, '{1, 1, 1}, '{1, 8, 255}, '{0, 4, 2},
                      '{1, 2, 0}, '{1, 5, 4}, '{0, 8, 1}, '{1, 3, 3}};
        calm = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        configure(1'b1, 8'd8, 8'd3);

        // Headers and linktests are ignored while disconnected; registering still works.
        send_req(build_request(hsce_pkg::REQ_HEADER, hsce_pkg::CTRL_SID, hsce_pkg::ST_DATA,
                               8'd0, 32'h0, 1'b0));
        send_req(build_request(hsce_pkg::REQ_LINKTEST, 16'd0, 8'd0, 8'd0, 32'h0, 1'b1));
        send_req(build_request(hsce_pkg::REQ_REGISTER, 16'd0, hsce_pkg::ST_DATA,
                               8'd0, 32'h0, 1'b0));
        send_req(build_request(hsce_pkg::REQ_RETIRE, 16'd0, 8'd0, 8'd0, 32'h1234, 1'b0));
        // Link open clears the table; data before select is dropped.
        send_req(build_request(hsce_pkg::REQ_LINK, 16'd0, 8'd0, 8'd0, 32'h0, 1'b0));
        send_req(build_request(hsce_pkg::REQ_HEADER, 16'h0000, hsce_pkg::ST_DATA,
                               8'd0, 32'h55, 1'b0));
        send_req(build_request(hsce_pkg::REQ_HEADER, hsce_pkg::CTRL_SID,
                               hsce_pkg::ST_SELECT_REQ, 8'd0, 32'hFFFFFFFF, 1'b0));
        send_req(build_request(hsce_pkg::REQ_HEADER, hsce_pkg::CTRL_SID,
                               hsce_pkg::ST_SELECT_REQ, 8'd0, 32'hFFFFFFFF, 1'b0));
        // Fill a few slots, including an overwrite of an existing id.
        send_req(build_request(hsce_pkg::REQ_REGISTER, 16'd0, hsce_pkg::ST_LINKTEST_RSP,
                               8'd0, 32'hFFFFFFFF, 1'b0));
        send_req(build_request(hsce_pkg::REQ_REGISTER, 16'd0, hsce_pkg::ST_DATA,
                               8'd0, 32'h0, 1'b0));
        send_req(build_request(hsce_pkg::REQ_REGISTER, 16'd0, hsce_pkg::ST_DESELECT_RSP,
                               8'd0, 32'hA5A5, 1'b0));
        send_req(build_request(hsce_pkg::REQ_REGISTER, 16'd0, hsce_pkg::ST_DATA,
                               8'd0, 32'h0, 1'b0));
        // Matched data, delivered data, linktest exchange, rejects.
        send_req(build_request(hsce_pkg::REQ_HEADER, hsce_pkg::CTRL_SID, hsce_pkg::ST_DATA,
                               8'd0, 32'h0, 1'b0));
        send_req(build_request(hsce_pkg::REQ_HEADER, 16'h1234, hsce_pkg::ST_DATA,
                               8'hFF, 32'h77, 1'b1));
        send_req(build_request(hsce_pkg::REQ_HEADER, hsce_pkg::CTRL_SID,
                               hsce_pkg::ST_LINKTEST_REQ, 8'hFF, 32'hFFFFFFFF, 1'b1));
        send_req(build_request(hsce_pkg::REQ_HEADER, hsce_pkg::CTRL_SID,
                               hsce_pkg::ST_LINKTEST_RSP, 8'd0, 32'hFFFFFFFF, 1'b0));
        send_req(build_request(hsce_pkg::REQ_HEADER, hsce_pkg::CTRL_SID, 8'd8,
                               8'd0, 32'h1, 1'b0));
        send_req(build_request(hsce_pkg::REQ_HEADER, hsce_pkg::CTRL_SID, 8'd255,
                               8'd0, 32'h2, 1'b0));
        send_req(build_request(hsce_pkg::REQ_HEADER, hsce_pkg::CTRL_SID,
                               hsce_pkg::ST_REJECT_REQ, 8'd0, 32'h3, 1'b0));
        // Deselect drops data entries; select.rsp with a bad then a good status.
        send_req(build_request(hsce_pkg::REQ_HEADER, hsce_pkg::CTRL_SID,
                               hsce_pkg::ST_DESELECT_REQ, 8'd0, 32'h4, 1'b0));
        send_req(build_request(hsce_pkg::REQ_REGISTER, 16'd0, hsce_pkg::ST_SELECT_RSP,
                               8'd0, 32'h9, 1'b0));
        send_req(build_request(hsce_pkg::REQ_HEADER, hsce_pkg::CTRL_SID,
                               hsce_pkg::ST_SELECT_RSP, 8'h01, 32'h9, 1'b0));
        send_req(build_request(hsce_pkg::REQ_HEADER, hsce_pkg::CTRL_SID,
                               hsce_pkg::ST_SELECT_RSP, 8'h00, 32'h9, 1'b0));
        send_req(build_request(hsce_pkg::REQ_HEADER, hsce_pkg::CTRL_SID,
                               hsce_pkg::ST_DESELECT_RSP, 8'd0, 32'hA5A5, 1'b0));
        // Linktest failures up to the limit close the link.
        send_req(build_request(hsce_pkg::REQ_HEADER, hsce_pkg::CTRL_SID,
                               hsce_pkg::ST_SELECT_REQ, 8'd0, 32'h5, 1'b0));
        send_req(build_request(hsce_pkg::REQ_LINKTEST, 16'd0, 8'd0, 8'd0, 32'h0, 1'b0));
        repeat (3) send_req(build_request(hsce_pkg::REQ_LINKTEST, 16'd0, 8'd0, 8'd0,
                                          32'h0, 1'b1));
        // Control header with a bad session id, separate, and link loss.
        send_req(build_request(hsce_pkg::REQ_LINK, 16'd0, 8'd0, 8'd0, 32'h0, 1'b0));
        send_req(build_request(hsce_pkg::REQ_HEADER, 16'h0000, hsce_pkg::ST_SELECT_REQ,
                               8'd0, 32'h6, 1'b0));
        send_req(build_request(hsce_pkg::REQ_LINK, 16'd0, 8'd0, 8'd0, 32'h0, 1'b0));
        send_req(build_request(hsce_pkg::REQ_HEADER, hsce_pkg::CTRL_SID,
                               hsce_pkg::ST_SEPARATE_REQ, 8'd0, 32'h7, 1'b0));
        send_req(build_request(hsce_pkg::REQ_LINK, 16'd0, 8'd0, 8'd0, 32'h0, 1'b0));
        send_req(build_request(hsce_pkg::REQ_LINK, 16'd0, 8'd0, 8'd0, 32'h0, 1'b1));

        for (int p = 0; p < 8; p++) begin
            drain();
            configure(phase_cfg[p][0][0], 8'(phase_cfg[p][1]), 8'(phase_cfg[p][2]));
            // With the highest failure limit, run the count all the way up.
            if (phase_cfg[p][2] == 255) begin
                send_req(build_request(hsce_pkg::REQ_LINK, 16'd0, 8'd0, 8'd0, 32'h0, 1'b0));
                send_req(build_request(hsce_pkg::REQ_HEADER, hsce_pkg::CTRL_SID,
                                       hsce_pkg::ST_SELECT_REQ, 8'd0, 32'h0, 1'b0));
                repeat (256) send_req(build_request(hsce_pkg::REQ_LINKTEST, 16'd0, 8'd0,
                                                    8'd0, 32'h0, 1'b1));
            end
            for (int i = 0; i < 180; i++) begin
                if (i % 50 == 0) calm = ($urandom_range(0, 9) < 3);
                send_req(random_request());
            end
        end

        drain();
        if (board.errors == 0 && board.pending() == 0)
            $display("hsms_session_control_engine: match");
        else
            $display("hsms_session_control_engine: mismatch");
        $finish;
    end
endmodule

/* sim.f */
+incdir+src
src/hsce_pkg.sv
src/hsce_slot_table.sv
src/hsms_session_control_engine.sv
tb/testbench.sv
